// ----- rtl/rvu_pkg.sv -----
// ----------------------------------------------------------------------------
// rvu_pkg
// Shared types and fixed constants of the rotation vector unwrap core.
// ----------------------------------------------------------------------------
`default_nettype none

package rvu_pkg;

   // 2*pi in unsigned Q32
   localparam logic [35:0] TWO_PI_Q32 = 36'd26986075409;
   // quotient bits of (v.w - |v|^2) / theta in Q32
   localparam int Y_BITS = 42;
   // quotient bits of the turn count division
   localparam int KQ_BITS = 9;
   localparam int TURN_W = 6;
   localparam logic [TURN_W-1:0] TURN_POS_CAP = 6'd31;
   localparam logic [TURN_W-1:0] TURN_NEG_CAP = 6'd32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_SUM,
      ST_SQRT,
      ST_NUM,
      ST_QLOAD,
      ST_QDIV,
      ST_KLOAD,
      ST_KDIV,
      ST_KSET,
      ST_KT,
      ST_LKT,
      ST_MUL2,
      ST_DLOAD,
      ST_DDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_in;
      logic load_kt;
      logic mul_step;
      logic div_load;
      logic div_step;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/rotation_vector_unwrap_core.sv -----
// ----------------------------------------------------------------------------
// rotation_vector_unwrap_core
// Unwraps a stream of rotation vectors across 2*pi turns, one beat at a time.
// ----------------------------------------------------------------------------
// Input beats carry rot_x/y/z on req_tdata and first_of_run on req_tuser.
// Result beats carry out_x/y/z and turns on rsp_tdata and saturated on rsp_tuser.
// One result beat per input beat, in order. The core works on one beat at a
// time: req_tready is high only while it is idle. A beat holds the core from
// its accepting cycle to the cycle that loads its result, after which the next
// beat can be taken at once. A first-of-run beat, or one with no previous
// vector, goes straight to the result; a zero-length beat stops after the
// multiply pass. Any other beat runs the shared multiply pass for |v|^2 and
// v.w, the square root and the scale multiply over RW = min(COMPONENT_WIDTH,
// 28) bits each, the theta division for 42 quotient bits, the turn division
// for 9 and the per-component scale division for COMPONENT_WIDTH + 1. When
// the theta quotient overflows, the theta and turn divisions are skipped.
// The result sits in an output register, so a new beat is taken while it
// waits; when rsp_tready stays low the next result holds in the core until the
// register frees up. Reset clears the previous vector and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_vector_unwrap_core #(
   parameter int COMPONENT_WIDTH = 24,
   parameter int FRACTION_BITS = 16
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_tvalid,
   output logic req_tready,
   // rot_x, rot_y, rot_z
   input  wire [((3*COMPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   // first_of_run
   input  wire [0:0] req_tuser,
   output logic rsp_tvalid,
   input  wire  rsp_tready,
   // out_x, out_y, out_z, turns
   output logic [((3*COMPONENT_WIDTH+6+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic [0:0] rsp_tuser
);
   import rvu_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int FB = FRACTION_BITS;
   localparam int DROP = (CW > 28) ? (CW - 28) : 0;
   localparam int RW = CW - DROP;
   localparam int MW = 2 * RW + 1;
   localparam int QB = 32 - FB + DROP;
   localparam int QCW = MW + Y_BITS;
   localparam int TPW = FB + 3;
   localparam int KTW = FB + 9;
   localparam int QQ = CW + 1;
   localparam int ODW = ((3 * CW + TURN_W + 7) / 8) * 8;
   localparam logic [63:0] TP_L =
      ({28'd0, TWO_PI_Q32} + (64'd1 << (31 - FB))) >> (32 - FB);
   localparam logic [TPW-1:0] TP_C = TPW'(TP_L);
   localparam logic [36:0] TWO_T = {TWO_PI_Q32, 1'b0};

   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic pass_ff, pass_in;
   logic have_prev_ff, have_prev_in;
   logic signed [CW-1:0] prev_ff [3];
   logic signed [CW-1:0] prev_in [3];
   logic [2*RW-1:0] sq_ff, sq_in, rad_ff, rad_in;
   logic signed [2*RW:0] dot_ff, dot_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW:0] srem_ff, srem_in;
   logic neg_ff, neg_in, qsat_ff, qsat_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic [RW-1:0] qrem_ff, qrem_in;
   logic [Y_BITS-1:0] qlow_ff, qlow_in, y_ff, y_in;
   logic [35:0] krem_ff, krem_in;
   logic [KQ_BITS-1:0] klow_ff, klow_in, kq_ff, kq_in;
   logic [TURN_W-1:0] kmag_ff, kmag_in;
   logic signed [TURN_W-1:0] k_ff, k_in;
   logic [KTW-1:0] kt_ff, kt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic signed [TURN_W-1:0] ok_ff, ok_in;
   logic osat_ff, osat_in;

   lane_ctrl_type lctl;
   logic signed [CW-1:0] vin [3];
   logic [2*RW-1:0] sq_t [3];
   logic signed [2*RW:0] dot_t [3];
   logic signed [CW-1:0] res [3];
   logic sat [3];

   logic [2*RW-1:0] sq_sum;
   logic signed [2*RW+1:0] num;
   logic [RW+2:0] st, strial;
   logic [QCW-1:0] nx;
   logic [RW:0] qt;
   logic [43:0] kx;
   logic [36:0] kt_step;

   assign vin[0] = req_tdata[CW-1:0];
   assign vin[1] = req_tdata[2*CW-1:CW];
   assign vin[2] = req_tdata[3*CW-1:2*CW];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rvu_lane #(
         .COMPONENT_WIDTH(CW),
         .FRACTION_BITS(FB)
      ) u_lane (
         .clock(clock),
         .ctrl(lctl),
         .comp_v(vin[i]),
         .comp_w(prev_ff[i]),
         .root(root_ff),
         .kt(kt_ff),
         .k_neg(neg_ff),
         .pass(pass_ff),
         .sq_term(sq_t[i]),
         .dot_term(dot_t[i]),
         .res(res[i]),
         .sat(sat[i])
      );
   end

   assign sq_sum = sq_t[0] + sq_t[1] + sq_t[2];
   assign num = (2*RW+2)'(dot_ff) - $signed({2'b00, sq_ff});
   assign st = {srem_ff, rad_ff[2*RW-1 -: 2]};
   assign strial = (RW+3)'({root_ff, 2'b01});
   assign nx = QCW'(mag_ff) << QB;
   assign qt = {qrem_ff, qlow_ff[Y_BITS-1]};
   assign kx = {1'b0, y_ff, 1'b0} + 44'(TWO_PI_Q32);
   assign kt_step = {krem_ff, klow_ff[KQ_BITS-1]};

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 6'd1;
      pass_in = pass_ff;
      have_prev_in = have_prev_ff;
      prev_in = prev_ff;
      sq_in = sq_ff;
      dot_in = dot_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      neg_in = neg_ff;
      qsat_in = qsat_ff;
      mag_in = mag_ff;
      qrem_in = qrem_ff;
      qlow_in = qlow_ff;
      y_in = y_ff;
      krem_in = krem_ff;
      klow_in = klow_ff;
      kq_in = kq_ff;
      kmag_in = kmag_ff;
      k_in = k_ff;
      kt_in = kt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      ok_in = ok_ff;
      osat_in = osat_ff;
      lctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lctl.load_in = 1'b1;
               pass_in = req_tuser[0] | ~have_prev_ff;
               cnt_in = '0;
               state_in = (req_tuser[0] | ~have_prev_ff) ? ST_DONE : ST_MUL1;
            end
         end
         ST_MUL1: begin
            lctl.mul_step = 1'b1;
            if (cnt_ff == 6'(RW - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sq_in = sq_sum;
            dot_in = dot_t[0] + dot_t[1] + dot_t[2];
            rad_in = sq_sum;
            root_in = '0;
            srem_in = '0;
            cnt_in = '0;
            if (sq_sum == '0) begin
               pass_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (st >= strial) begin
               srem_in = (RW+1)'(st - strial);
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               srem_in = (RW+1)'(st);
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            if (cnt_ff == 6'(RW - 1)) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            neg_in = num[2*RW+1];
            mag_in = MW'(num[2*RW+1] ? -num : num);
            state_in = ST_QLOAD;
         end
         ST_QLOAD: begin
            qsat_in = QCW'(mag_ff) >= (QCW'(root_ff) << (Y_BITS - QB));
            qrem_in = RW'(nx >> Y_BITS);
            qlow_in = nx[Y_BITS-1:0];
            y_in = '0;
            cnt_in = '0;
            state_in = (QCW'(mag_ff) >= (QCW'(root_ff) << (Y_BITS - QB))) ? ST_KSET : ST_QDIV;
         end
         ST_QDIV: begin
            if (qt >= (RW+1)'(root_ff)) begin
               qrem_in = RW'(qt - (RW+1)'(root_ff));
               y_in = {y_ff[Y_BITS-2:0], 1'b1};
            end else begin
               qrem_in = RW'(qt);
               y_in = {y_ff[Y_BITS-2:0], 1'b0};
            end
            qlow_in = qlow_ff << 1;
            if (cnt_ff == 6'(Y_BITS - 1)) begin
               state_in = ST_KLOAD;
            end
         end
         ST_KLOAD: begin
            krem_in = 36'(kx >> KQ_BITS);
            klow_in = kx[KQ_BITS-1:0];
            kq_in = '0;
            cnt_in = '0;
            state_in = ST_KDIV;
         end
         ST_KDIV: begin
            if (kt_step >= TWO_T) begin
               krem_in = 36'(kt_step - TWO_T);
               kq_in = {kq_ff[KQ_BITS-2:0], 1'b1};
            end else begin
               krem_in = 36'(kt_step);
               kq_in = {kq_ff[KQ_BITS-2:0], 1'b0};
            end
            klow_in = klow_ff << 1;
            if (cnt_ff == 6'(KQ_BITS - 1)) begin
               state_in = ST_KSET;
            end
         end
         ST_KSET: begin
            if (neg_ff) begin
               kmag_in = (qsat_ff || kq_ff > KQ_BITS'(TURN_NEG_CAP)) ? TURN_NEG_CAP
                                                                  : kq_ff[TURN_W-1:0];
               k_in = ~kmag_in + 6'd1;
            end else begin
               kmag_in = (qsat_ff || kq_ff > KQ_BITS'(TURN_POS_CAP)) ? TURN_POS_CAP
                                                                  : kq_ff[TURN_W-1:0];
               k_in = kmag_in;
            end
            state_in = ST_KT;
         end
         ST_KT: begin
            kt_in = KTW'(kmag_ff * TP_C);
            state_in = ST_LKT;
         end
         ST_LKT: begin
            lctl.load_kt = 1'b1;
            cnt_in = '0;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            lctl.mul_step = 1'b1;
            if (cnt_ff == 6'(RW - 1)) begin
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            lctl.div_load = 1'b1;
            cnt_in = '0;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            lctl.div_step = 1'b1;
            if (cnt_ff == 6'(QQ - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               ox_in = res[0];
               oy_in = res[1];
               oz_in = res[2];
               ok_in = pass_ff ? '0 : k_ff;
               osat_in = sat[0] | sat[1] | sat[2];
               prev_in[0] = res[0];
               prev_in[1] = res[1];
               prev_in[2] = res[2];
               have_prev_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff[0] <= '0;
         prev_ff[1] <= '0;
         prev_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      pass_ff <= pass_in;
      sq_ff <= sq_in;
      dot_ff <= dot_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      neg_ff <= neg_in;
      qsat_ff <= qsat_in;
      mag_ff <= mag_in;
      qrem_ff <= qrem_in;
      qlow_ff <= qlow_in;
      y_ff <= y_in;
      krem_ff <= krem_in;
      klow_ff <= klow_in;
      kq_ff <= kq_in;
      kmag_ff <= kmag_in;
      k_ff <= k_in;
      kt_ff <= kt_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oz_ff <= oz_in;
      ok_ff <= ok_in;
      osat_ff <= osat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = ODW'({ok_ff, oz_ff, oy_ff, ox_ff});
   assign rsp_tuser = osat_ff;

endmodule

`default_nettype wire

// ----- rtl/rvu_lane.sv -----
// ----------------------------------------------------------------------------
// rvu_lane
// One vector component: bit-serial products for |v|^2 and v.w, the bit-serial
// scale product c*k*2pi, its rounded division by theta and the saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rvu_lane #(
   parameter int COMPONENT_WIDTH = 24,
   parameter int FRACTION_BITS = 16,
   localparam int DROP = (COMPONENT_WIDTH > 28) ? (COMPONENT_WIDTH - 28) : 0,
   localparam int RW = COMPONENT_WIDTH - DROP,
   localparam int KTW = FRACTION_BITS + 9
) (
   input  wire                               clock,
   input  rvu_pkg::lane_ctrl_type            ctrl,
   input  wire signed [COMPONENT_WIDTH-1:0]  comp_v,
   input  wire signed [COMPONENT_WIDTH-1:0]  comp_w,
   input  wire [RW-1:0]                      root,
   input  wire [KTW-1:0]                     kt,
   input  wire                               k_neg,
   input  wire                               pass,
   output logic [2*RW-1:0]                   sq_term,
   output logic signed [2*RW:0]              dot_term,
   output logic signed [COMPONENT_WIDTH-1:0] res,
   output logic                              sat
);
   import rvu_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int PRW = RW + ((RW > KTW) ? RW : KTW);
   localparam int QQ = CW + 1;
   localparam int CMPW = PRW + QQ + 3;
   localparam logic signed [CW+2:0] HI = (CW+3)'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic signed [CW+2:0] LO = -HI - (CW+3)'(1);

   logic signed [CW-1:0] v_ff, v_in;
   logic                 cneg_ff, cneg_in, dneg_ff, dneg_in;
   logic [RW-1:0]        ma_ff, ma_in;
   logic [PRW-1:0]       mba_ff, mba_in, mbb_ff, mbb_in, acca_ff, acca_in, accb_ff, accb_in;
   logic [RW:0]          drem_ff, drem_in;
   logic [QQ-1:0]        dlow_ff, dlow_in, dq_ff, dq_in;
   logic                 dsat_ff, dsat_in;

   logic signed [RW-1:0] c_in, w_in, c_hold;
   logic [RW-1:0]        cm_in, wm_in, cm_hold;
   logic [PRW+1:0]       mval;
   logic [RW:0]          r2;
   logic [CMPW-1:0]      mwide;
   logic [RW+1:0]        dt;
   logic                 dge;
   logic                 an;
   logic signed [CW+2:0] sv, sa, ssum;

   assign c_in = RW'(comp_v >>> DROP);
   assign w_in = RW'(comp_w >>> DROP);
   assign c_hold = RW'(v_ff >>> DROP);
   assign cm_in = c_in[RW-1] ? (~c_in + 1'b1) : c_in;
   assign wm_in = w_in[RW-1] ? (~w_in + 1'b1) : w_in;
   assign cm_hold = c_hold[RW-1] ? (~c_hold + 1'b1) : c_hold;

   assign mval = (PRW+2)'({acca_ff, 1'b0}) + (PRW+2)'(root);
   assign r2 = {root, 1'b0};
   assign mwide = CMPW'(mval);
   assign dt = {drem_ff, dlow_ff[QQ-1]};
   assign dge = dt >= (RW+2)'(r2);

   always_comb begin
      v_in = v_ff;
      cneg_in = cneg_ff;
      dneg_in = dneg_ff;
      ma_in = ma_ff;
      mba_in = mba_ff;
      mbb_in = mbb_ff;
      acca_in = acca_ff;
      accb_in = accb_ff;
      drem_in = drem_ff;
      dlow_in = dlow_ff;
      dq_in = dq_ff;
      dsat_in = dsat_ff;
      if (ctrl.load_in) begin
         v_in = comp_v;
         cneg_in = c_in[RW-1];
         dneg_in = c_in[RW-1] ^ w_in[RW-1];
         ma_in = cm_in;
         mba_in = PRW'(cm_in);
         mbb_in = PRW'(wm_in);
         acca_in = '0;
         accb_in = '0;
      end
      if (ctrl.load_kt) begin
         ma_in = cm_hold;
         mba_in = PRW'(kt);
         acca_in = '0;
      end
      if (ctrl.mul_step) begin
         if (ma_ff[0]) begin
            acca_in = acca_ff + mba_ff;
            accb_in = accb_ff + mbb_ff;
         end
         ma_in = ma_ff >> 1;
         mba_in = mba_ff << 1;
         mbb_in = mbb_ff << 1;
      end
      if (ctrl.div_load) begin
         dsat_in = mwide >= (CMPW'(r2) << QQ);
         drem_in = (RW+1)'(mwide >> QQ);
         dlow_in = mwide[QQ-1:0];
         dq_in = '0;
      end
      if (ctrl.div_step) begin
         drem_in = dge ? (RW+1)'(dt - (RW+2)'(r2)) : (RW+1)'(dt);
         dlow_in = dlow_ff << 1;
         dq_in = {dq_ff[QQ-2:0], dge};
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      cneg_ff <= cneg_in;
      dneg_ff <= dneg_in;
      ma_ff <= ma_in;
      mba_ff <= mba_in;
      mbb_ff <= mbb_in;
      acca_ff <= acca_in;
      accb_ff <= accb_in;
      drem_ff <= drem_in;
      dlow_ff <= dlow_in;
      dq_ff <= dq_in;
      dsat_ff <= dsat_in;
   end

   assign sq_term = acca_ff[2*RW-1:0];
   assign dot_term = dneg_ff ? -$signed({1'b0, accb_ff[2*RW-1:0]})
                             : $signed({1'b0, accb_ff[2*RW-1:0]});

   assign an = cneg_ff ^ k_neg;
   assign sv = (CW+3)'(v_ff);
   assign sa = $signed((CW+3)'(dq_ff));
   assign ssum = an ? (sv - sa) : (sv + sa);

   always_comb begin
      if (pass) begin
         res = v_ff;
         sat = 1'b0;
      end else if (dsat_ff) begin
         res = an ? CW'(LO) : CW'(HI);
         sat = 1'b1;
      end else if (ssum > HI) begin
         res = CW'(HI);
         sat = 1'b1;
      end else if (ssum < LO) begin
         res = CW'(LO);
         sat = 1'b1;
      end else begin
         res = ssum[CW-1:0];
         sat = 1'b0;
      end
   end

endmodule

`default_nettype wire
